// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package spq_pkg;

  // Built number of entries in the sorted store.
  localparam int unsigned DEPTH = 16;

  // Fixed field widths of the channels.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 2;

  // Internal widths derived from the depth.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the incoming operation and value
    logic execute;  // update the store and load the result registers
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== src/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg for the state enum and the command struct.
`default_nettype none

module spq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spq_pkg::spq_cmd_t  cmd_o
);

  spq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.latch   = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = spq_pkg::S_RESP;
      end
      spq_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        // The next item may enter in the cycle the result is taken.
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.latch = 1'b1;
            state_d     = spq_pkg::S_EXEC;
          end else begin
            state_d = spq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/spq_datapath.sv =====
// Datapath of the sorted priority queue: shift-register store, count,
// capacity register and result registers. Depends on spq_pkg.
`default_nettype none

module spq_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire spq_pkg::spq_cmd_t             cmd_i,
  input  wire logic                          operation_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0] value_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [spq_pkg::CAP_W-1:0]     cfg_data_i,
  output logic [spq_pkg::STAT_W-1:0]         status_o,
  output logic signed [spq_pkg::DATA_W-1:0]  removed_value_o,
  output logic [spq_pkg::OCC_W-1:0]          occupancy_o
);

  localparam int unsigned DEPTH = spq_pkg::DEPTH;
  localparam int unsigned CNT_W = spq_pkg::CNT_W;
  localparam int unsigned CMP_W = spq_pkg::CMP_W;

  logic                              op_q;
  logic signed [spq_pkg::DATA_W-1:0] val_q;
  logic signed [spq_pkg::DATA_W-1:0] entries_q [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] ins_d     [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] rem_d     [DEPTH];
  logic [DEPTH-1:0]                  lt;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [spq_pkg::CAP_W-1:0]         cap_q;
  logic [CMP_W-1:0]                  eff_cap;
  logic                              full, empty;
  logic [spq_pkg::STAT_W-1:0]        status_q, status_d;
  logic signed [spq_pkg::DATA_W-1:0] removed_q, removed_d;
  logic                              do_insert, do_remove;

  // Capacity saturates at the built depth.
  always_comb begin
    if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  assign full      = CMP_W'(count_q) >= eff_cap;
  assign empty     = (count_q == '0);
  assign do_insert = (op_q == spq_pkg::OP_INSERT) && !full;
  assign do_remove = (op_q == spq_pkg::OP_REMOVE) && !empty;

  // Each cell compares the new value with its own entry. Because the store
  // is sorted, the flags are clear below the insert point and set above it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign lt[i] = (CNT_W'(i) < count_q) && (val_q < entries_q[i]);

    if (i == 0) begin : g_first
      assign ins_d[i] = (lt[i] || (count_q == CNT_W'(i))) ? val_q : entries_q[i];
    end else begin : g_rest
      assign ins_d[i] = lt[i-1] ? entries_q[i-1] :
                        (lt[i] || (count_q == CNT_W'(i))) ? val_q : entries_q[i];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rem_d[i] = entries_q[i];
    end else begin : g_mid
      assign rem_d[i] = entries_q[i+1];
    end
  end

  always_comb begin
    count_d   = count_q;
    status_d  = spq_pkg::ST_DONE;
    removed_d = '0;
    if (op_q == spq_pkg::OP_INSERT) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        removed_d = entries_q[0];
        count_d   = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= spq_pkg::CAP_RESET;
    end else begin
      if (cmd_i.execute) begin
        count_q <= count_d;
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      val_q <= value_i;
    end
    if (cmd_i.execute) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.execute && do_insert) begin
        entries_q[i] <= ins_d[i];
      end else if (cmd_i.execute && do_remove) begin
        entries_q[i] <= rem_d[i];
      end
    end
  end

  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign occupancy_o     = spq_pkg::OCC_W'(count_q);

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue, top level: joins the controller and the datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// The block keeps up to 16 signed 32-bit values in ascending order. Each
// input transaction carries an operation (insert or remove smallest) and a
// value; each one produces exactly one output transaction with a status,
// the removed value (zero unless a remove succeeded) and the occupancy
// after the item. Equal values leave in the order they arrived.
//
// An accepted item is captured when taken, applied to the shift-register
// store in the next cycle, and its result is shown from the one after.
// The store update is a single pass of per-cell compares, and the
// controller takes one item at a time: the next input transaction is
// accepted in the same cycle its predecessor's result is taken. While the
// receiver stalls, the result is held and no new input is accepted.
//
// The configuration channel writes the capacity (values above the depth
// act as the depth, zero refuses every insert). It is always ready; the
// user must write it only while the queue is idle, which the block does
// not enforce. Reset empties the queue and sets the capacity to 16;
// stored entries need no clearing since only occupied slots are ever read.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0] value_i,
  // Output channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [spq_pkg::STAT_W-1:0]             status_o,
  output logic signed [spq_pkg::DATA_W-1:0]      removed_value_o,
  output logic [spq_pkg::OCC_W-1:0]              occupancy_o,
  // Configuration channel: capacity register.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [spq_pkg::CAP_W-1:0]         cfg_data_i
);

  spq_pkg::spq_cmd_t cmd;

  // The capacity register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`default_nettype none

module spq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [spq_pkg::STAT_W-1:0]        status_o,
  input wire logic signed [spq_pkg::DATA_W-1:0] removed_value_o,
  input wire logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  // A result waiting for the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(removed_value_o) && $stable(occupancy_o))
    else $error("output transaction changed while stalled");

  // Only a successful remove reports a nonzero value.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != spq_pkg::ST_DONE) |-> removed_value_o == '0)
    else $error("refused item reported a removed value");

  // A remove is refused only when nothing is stored.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == spq_pkg::ST_EMPTY) |-> occupancy_o == '0)
    else $error("empty refusal with nonzero occupancy");

  // Occupancy never exceeds the built depth.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= spq_pkg::OCC_W'(spq_pkg::DEPTH))
    else $error("occupancy above depth");

  // A new result appears only after an input transaction was taken.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an accepted input");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .removed_value_o (removed_value_o),
  .occupancy_o     (occupancy_o)
);

`default_nettype wire

// ===== sim/tb_sorted_priority_queue.sv =====
// Self-checking testbench for the sorted priority queue (insert / remove smallest).
// Depends on spq_pkg and the sorted_priority_queue RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  // Number of trailing cycles allowed after the last result.
  localparam int SETTLE_CYCLES  = 6;
  // Upper bound on the wait for outstanding results at the very end.
  localparam int DRAIN_LIMIT    = 5000;
  // Length of the deliberate receiver hold-off that backs up the input side.
  localparam int LONG_HOLD      = 200;
  // Random part: phases of one capacity setting each.
  localparam int NUM_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 128;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One output transaction as the block presents it.
  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  removed;
    logic [OCC_W-1:0]          occupancy;
  } queue_result_t;

  // A directed row is either an input item or a capacity write.
  typedef enum logic {
    ROW_ITEM,
    ROW_CAPACITY
  } row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    op_e                       op;
    logic signed [DATA_W-1:0]  value;    // item value, or the capacity on a write
    bit                        typed;    // expected result is given in the row
    queue_result_t             result;
  } stim_row_t;

  // Ports of the block. Every input starts at a known value.
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        operation_i = 1'b0;
  logic signed [DATA_W-1:0]    value_i     = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [STAT_W-1:0]           status_o;
  logic signed [DATA_W-1:0]    removed_value_o;
  logic [OCC_W-1:0]            occupancy_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CAP_W-1:0]            cfg_data_i  = '0;

  // Shadow of the block's state, kept by the predictor.
  logic signed [DATA_W-1:0]    sorted_store[$];
  logic [CAP_W-1:0]            capacity_shadow = CAP_RESET;

  // Results that accepted items still owe, oldest first.
  queue_result_t               owed_results[$];

  // Handshake flags, written at the rising edge and read at the falling one.
  bit                          in_took;
  bit                          cfg_took;
  // Side information for the item currently offered on the input channel.
  bit                          cur_typed;
  queue_result_t               cur_expect;
  // Request from the stimulus process for a long receiver hold-off.
  bit                          long_hold_req;

  int                          error_count;
  stim_row_t                   directed_rows[$];

  sorted_priority_queue i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .occupancy_o     (occupancy_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // 4 ns clock period.
  always #2 clk_i = ~clk_i;

  // Applies one item to the shadow queue and returns the result the block
  // must give for it. An insert lands behind every stored value that is
  // less than or equal to it, which keeps equal values in arrival order.
  function automatic queue_result_t apply_queue_op(input op_e op,
                                                   input logic signed [DATA_W-1:0] v);
    queue_result_t res;
    int            limit;
    int            pos;
    res.status  = ST_DONE;
    res.removed = '0;
    // Capacities above the built depth act as the depth; zero refuses all.
    limit = (capacity_shadow > DEPTH) ? DEPTH : int'(capacity_shadow);
    if (op == OP_INSERT) begin
      if (sorted_store.size() >= limit) begin
        res.status = ST_FULL;
      end else begin
        pos = sorted_store.size();
        while (pos > 0 && v < sorted_store[pos-1]) pos--;
        sorted_store.insert(pos, v);
      end
    end else begin
      if (sorted_store.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed = sorted_store.pop_front();
      end
    end
    res.occupancy = OCC_W'(sorted_store.size());
    return res;
  endfunction

  // Everything that happens on a rising edge is observed here: accepted
  // configuration writes update the shadow capacity, accepted input
  // transactions are run through the predictor, and accepted output
  // transactions are compared field by field with the oldest owed result.
  // Outputs are read before the block's own updates of this edge land.
  always @(posedge clk_i) begin : edge_monitor
    queue_result_t predicted;
    queue_result_t want;
    in_took  = in_valid_i && in_ready_o;
    cfg_took = cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_took) capacity_shadow = cfg_data_i;
      if (in_took) begin
        // The predictor always advances; a typed row replaces its answer.
        predicted = apply_queue_op(op_e'(operation_i), value_i);
        owed_results.push_back(cur_typed ? cur_expect : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          error_count++;
          $display("%0t ns: result with nothing expected, actual status %0d value %0d occ %0d",
                   $time, status_o, removed_value_o, occupancy_o);
        end else begin
          want = owed_results.pop_front();
          if (status_o !== want.status) begin
            error_count++;
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_o);
          end
          if (removed_value_o !== want.removed) begin
            error_count++;
            $display("%0t ns: removed value mismatch, expected %0d, actual %0d",
                     $time, want.removed, removed_value_o);
          end
          if (occupancy_o !== want.occupancy) begin
            error_count++;
            $display("%0t ns: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occupancy, occupancy_o);
          end
        end
      end
    end
  end

  // Receiver side. It alternates between ready stretches and stalls of random
  // length, mostly short with the odd long one. When asked, it holds ready low
  // for a long fixed stretch so that the block backs up and refuses input.
  initial begin : result_sink
    int r;
    int len;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_ready_i <= 1'b1;
          len = $urandom_range(1, 24);
        end else if (r < 90) begin
          out_ready_i <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          len = $urandom_range(8, 40);
        end
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  // Offers one input transaction and holds it until the block takes it.
  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_item(input op_e op, input logic signed [DATA_W-1:0] v,
                           input bit typed, input queue_result_t want);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    cur_typed   = typed;
    cur_expect  = want;
    do @(negedge clk_i); while (!in_took);
  endtask

  // Random idle time on the input side: mostly none or short, rarely long.
  task automatic input_gap();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 55) len = 0;
    else if (r < 85) len = $urandom_range(1, 3);
    else if (r < 97) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      in_valid_i <= 1'b0;
      repeat (len) @(negedge clk_i);
    end
  endtask

  // Waits until every owed result has come back, plus the settle time, so the
  // capacity can be changed while the block is idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input op_e op,
                         input logic signed [DATA_W-1:0] v, input bit typed,
                         input status_e st, input logic signed [DATA_W-1:0] rem,
                         input int occ);
    stim_row_t row;
    row.kind             = kind;
    row.op               = op;
    row.value            = v;
    row.typed            = typed;
    row.result.status    = st;
    row.result.removed   = rem;
    row.result.occupancy = OCC_W'(occ);
    directed_rows.push_back(row);
  endtask

  // Main stimulus: reset, a directed table, then random phases that each run
  // under one capacity setting.
  initial begin : stimulus
    logic [CAP_W-1:0]          cap;
    int                        insert_pct;
    bit                        squeeze;
    op_e                       op;
    logic signed [DATA_W-1:0]  v;
    int                        drain;
    queue_result_t             none;

    none = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed table. The first block runs at the reset capacity of 16:
    // removing from an empty queue, inserting both extremes and equal values,
    // and draining it again in sorted order. A remove carries an all-ones
    // value to show the value is ignored. Then a capacity of two shows the
    // full refusal, and a capacity of zero with one value still stored
    // shows that inserts are refused while removes still work.
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_EMPTY, 32'sd0,  0);
    add_row(ROW_ITEM, OP_INSERT, 32'sd0,  1'b1, ST_DONE,  32'sd0,  1);
    add_row(ROW_ITEM, OP_INSERT, VAL_MAX, 1'b1, ST_DONE,  32'sd0,  2);
    add_row(ROW_ITEM, OP_INSERT, VAL_MIN, 1'b1, ST_DONE,  32'sd0,  3);
    add_row(ROW_ITEM, OP_INSERT, -32'sd1, 1'b1, ST_DONE,  32'sd0,  4);
    add_row(ROW_ITEM, OP_INSERT, 32'sd0,  1'b1, ST_DONE,  32'sd0,  5);
    add_row(ROW_ITEM, OP_INSERT, 32'sd1,  1'b1, ST_DONE,  32'sd0,  6);
    add_row(ROW_ITEM, OP_REMOVE, -32'sd1, 1'b1, ST_DONE,  VAL_MIN, 5);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  -32'sd1, 4);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  32'sd0,  3);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  32'sd0,  2);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  32'sd1,  1);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  VAL_MAX, 0);
    add_row(ROW_ITEM, OP_REMOVE, VAL_MAX, 1'b1, ST_EMPTY, 32'sd0,  0);
    add_row(ROW_CAPACITY, OP_INSERT, 32'sd2, 1'b0, ST_DONE, 32'sd0, 0);
    add_row(ROW_ITEM, OP_INSERT, 32'sd5,  1'b1, ST_DONE,  32'sd0,  1);
    add_row(ROW_ITEM, OP_INSERT, -32'sd5, 1'b1, ST_DONE,  32'sd0,  2);
    add_row(ROW_ITEM, OP_INSERT, 32'sd7,  1'b1, ST_FULL,  32'sd0,  2);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  -32'sd5, 1);
    add_row(ROW_CAPACITY, OP_INSERT, 32'sd0, 1'b0, ST_DONE, 32'sd0, 0);
    add_row(ROW_ITEM, OP_INSERT, 32'sd9,  1'b1, ST_FULL,  32'sd0,  1);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_DONE,  32'sd5,  0);
    add_row(ROW_ITEM, OP_INSERT, 32'sd9,  1'b1, ST_FULL,  32'sd0,  0);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b1, ST_EMPTY, 32'sd0,  0);
    // A capacity above the depth; the remaining rows go to the predictor.
    add_row(ROW_CAPACITY, OP_INSERT, 32'sd31, 1'b0, ST_DONE, 32'sd0, 0);
    add_row(ROW_ITEM, OP_INSERT, -32'sd2, 1'b0, ST_DONE,  32'sd0,  0);
    add_row(ROW_ITEM, OP_INSERT, 32'sd3,  1'b0, ST_DONE,  32'sd0,  0);
    add_row(ROW_ITEM, OP_REMOVE, 32'sd0,  1'b0, ST_DONE,  32'sd0,  0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAPACITY) begin
        wait_idle();
        write_capacity(directed_rows[i].value[CAP_W-1:0]);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].result);
        input_gap();
      end
    end

    // Random phases. The insert share swings between phases so the queue
    // both fills to its limit and runs dry; lowering the capacity after an
    // insert-heavy phase leaves more values stored than the new limit.
    // Two phases squeeze the block: the receiver holds off for a long time
    // while the sender keeps offering back to back.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      squeeze = 1'b0;
      case (phase)
        0:       begin cap = 5'd16; insert_pct = 80; squeeze = 1'b1; end
        1:       begin cap = 5'd4;  insert_pct = 60; end
        2:       begin cap = 5'd31; insert_pct = 85; end
        3:       begin cap = 5'd1;  insert_pct = 50; end
        4:       begin cap = 5'd0;  insert_pct = 40; end
        5:       begin cap = 5'd17; insert_pct = 85; end
        6:       begin cap = 5'd3;  insert_pct = 50; end
        7:       begin cap = 5'd16; insert_pct = 50; squeeze = 1'b1; end
        8:       begin cap = 5'd2;  insert_pct = 30; end
        9:       begin cap = CAP_W'($urandom_range(0, 31)); insert_pct = 60; end
        10:      begin cap = 5'd16; insert_pct = 70; end
        default: begin cap = 5'd8;  insert_pct = 25; end
      endcase
      wait_idle();
      write_capacity(cap);
      if (squeeze) long_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        // Extremes and a narrow band of small values give many equal keys;
        // the rest are full-width random patterns.
        case ($urandom_range(0, 9))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2, 3, 4: v = DATA_W'(int'($urandom_range(0, 8)) - 4);
          default: v = $urandom;
        endcase
        send_item(op, v, 1'b0, none);
        if (!squeeze) input_gap();
      end
    end

    // Let the last results come back, within a bound.
    in_valid_i <= 1'b0;
    drain = 0;
    while (owed_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (owed_results.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d results never arrived", $time, owed_results.size());
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a correct run finishes well inside this bound.
  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
sim/tb_sorted_priority_queue.sv
